// ----- sv/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Scanner modes, result kinds, error codes and the command record that
// travels from the scanner through the queue to the output sequencer.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Width of the running decoded-length counter (saturating)
  localparam int LENGTH_BITS = 16;

  // Command queue depth, must be a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Scanner modes
  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX1,
    MODE_SUR_BS,
    MODE_SUR_U,
    MODE_HEX2
  } mode_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_NOQUOTE = 3'd1;
  localparam logic [2:0] ERR_CTRL    = 3'd2;
  localparam logic [2:0] ERR_ESCAPE  = 3'd3;
  localparam logic [2:0] ERR_HEX     = 3'd4;
  localparam logic [2:0] ERR_SURR    = 3'd5;

  // One queued command: one to four results caused by one input item
  typedef struct packed {
    logic [1:0]      last_idx;  // number of results minus one
    kind_t           kind;
    logic [2:0]      err;
    logic [15:0]     len;
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
  } cmd_t;

  // Queue status toward producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- sv/jsu_front.sv -----
// ----------------------------------------------------------------------------
// jsu_front: string scanner
// Accepts one text byte per cycle while the queue has room, tracks
// string/escape/hex state, encodes code points to UTF-8 and pushes one command per item that has results.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  qstat_t     qstat,
  output logic       push,
  output cmd_t       push_cmd
);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  mode_t                  mode_r, mode_nxt;
  logic [15:0]            hex_r, hex_nxt;
  logic [15:0]            hi_r, hi_nxt;
  logic [1:0]             dig_r, dig_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;

  logic                   accept;
  logic                   hex_ok;
  logic [3:0]             dval;
  logic [15:0]            hex_new;
  logic                   is_hi, is_lo;
  logic [20:0]            cp_pair;
  logic                   esc_ok;
  logic [7:0]             esc_char;

  logic                   fail;
  logic [2:0]             fail_code;
  logic                   done;
  logic                   data;
  logic                   raw;
  logic [20:0]            cp;

  logic [3:0][7:0]        enc_bytes;
  logic [1:0]             enc_last;
  logic [2:0]             enc_n;
  logic [LENGTH_BITS:0]   cnt_sum;
  logic [LENGTH_BITS-1:0] cnt_add;
  logic [32:0]            cnt_ext;
  logic [15:0]            len16;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  // Hex digit decode
  always_comb begin
    hex_ok = 1'b1;
    dval   = in_byte[3:0];
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      dval = in_byte[3:0];
    end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                 (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
      dval = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_new = {hex_r[11:0], dval};
  assign is_hi   = (hex_new >= 16'hD800) && (hex_new <= 16'hDBFF);
  assign is_lo   = (hex_new >= 16'hDC00) && (hex_new <= 16'hDFFF);
  assign cp_pair = {1'b0, hi_r[9:0], hex_new[9:0]} + 21'h10000;

  // Single-character escapes
  always_comb begin
    esc_ok   = 1'b1;
    esc_char = in_byte;
    unique case (in_byte)
      8'h22:   esc_char = 8'h22;
      8'h5C:   esc_char = 8'h5C;
      8'h2F:   esc_char = 8'h2F;
      8'h62:   esc_char = 8'h08;
      8'h66:   esc_char = 8'h0C;
      8'h6E:   esc_char = 8'h0A;
      8'h72:   esc_char = 8'h0D;
      8'h74:   esc_char = 8'h09;
      default: esc_ok   = 1'b0;
    endcase
  end

  // Classify the current byte against the mode
  always_comb begin
    fail      = 1'b0;
    fail_code = ERR_NONE;
    done      = 1'b0;
    data      = 1'b0;
    raw       = 1'b0;
    cp        = {13'd0, in_byte};
    unique case (mode_r)
      MODE_IDLE: begin
        if (in_byte != CH_QUOTE) begin
          fail      = 1'b1;
          fail_code = ERR_SURR;
        end
      end
      MODE_BODY: begin
        if (in_byte == CH_QUOTE) begin
          done = 1'b1;
        end else if (in_byte == CH_BSL) begin
          data = 1'b0;
        end else if (in_byte == 8'h00) begin
          fail      = 1'b1;
          fail_code = ERR_NOQUOTE;
        end else if (in_byte < CH_SPACE) begin
          fail      = 1'b1;
          fail_code = ERR_CTRL;
        end else begin
          // plain bytes, 0x80..0xFF included, pass through as they are
          data = 1'b1;
          raw  = 1'b1;
        end
      end
      MODE_ESC: begin
        if (esc_ok) begin
          data = 1'b1;
          cp   = {13'd0, esc_char};
        end else if (in_byte != CH_U) begin
          fail      = 1'b1;
          fail_code = ERR_ESCAPE;
        end
      end
      MODE_HEX1, MODE_HEX2: begin
        if (!hex_ok) begin
          fail      = 1'b1;
          fail_code = ERR_HEX;
        end else if (dig_r == 2'd3) begin
          if (mode_r == MODE_HEX1) begin
            if (!is_hi) begin
              data = 1'b1;
              cp   = {5'd0, hex_new};
            end
          end else if (!is_lo) begin
            fail      = 1'b1;
            fail_code = ERR_SURR;
          end else begin
            data = 1'b1;
            cp   = cp_pair;
          end
        end
      end
      MODE_SUR_BS: begin
        if (in_byte != CH_BSL) begin
          fail      = 1'b1;
          fail_code = ERR_SURR;
        end
      end
      MODE_SUR_U: begin
        if (in_byte != CH_U) begin
          fail      = 1'b1;
          fail_code = ERR_SURR;
        end
      end
      default: begin
        fail      = 1'b1;
        fail_code = ERR_SURR;
      end
    endcase
  end

  // UTF-8 encoder
  always_comb begin
    enc_bytes = '0;
    if (raw || cp <= 21'h7F) begin
      enc_last     = 2'd0;
      enc_bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      enc_last     = 2'd1;
      enc_bytes[0] = 8'hC0 | {3'd0, cp[10:6]};
      enc_bytes[1] = 8'h80 | {2'd0, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      enc_last     = 2'd2;
      enc_bytes[0] = 8'hE0 | {4'd0, cp[15:12]};
      enc_bytes[1] = 8'h80 | {2'd0, cp[11:6]};
      enc_bytes[2] = 8'h80 | {2'd0, cp[5:0]};
    end else begin
      enc_last     = 2'd3;
      enc_bytes[0] = 8'hF0 | {5'd0, cp[20:18]};
      enc_bytes[1] = 8'h80 | {2'd0, cp[17:12]};
      enc_bytes[2] = 8'h80 | {2'd0, cp[11:6]};
      enc_bytes[3] = 8'h80 | {2'd0, cp[5:0]};
    end
  end

  // Saturating length count and reported length
  assign enc_n   = {1'b0, enc_last} + 3'd1;
  assign cnt_sum = {1'b0, cnt_r} + {{(LENGTH_BITS-2){1'b0}}, enc_n};
  assign cnt_add = cnt_sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : cnt_sum[LENGTH_BITS-1:0];
  assign cnt_ext = {{(33-LENGTH_BITS){1'b0}}, cnt_r};
  assign len16   = (cnt_ext > 33'hFFFF) ? 16'hFFFF : cnt_ext[15:0];

  // Next state
  always_comb begin
    mode_nxt = mode_r;
    hex_nxt  = hex_r;
    hi_nxt   = hi_r;
    dig_nxt  = dig_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (fail) begin
        mode_nxt = MODE_IDLE;
        dig_nxt  = 2'd0;
        cnt_nxt  = '0;
      end else begin
        unique case (mode_r)
          MODE_IDLE: begin
            mode_nxt = MODE_BODY;
            cnt_nxt  = '0;
          end
          MODE_BODY: begin
            if (done) begin
              mode_nxt = MODE_IDLE;
              cnt_nxt  = '0;
            end else if (in_byte == CH_BSL) begin
              mode_nxt = MODE_ESC;
            end
          end
          MODE_ESC: begin
            if (data) begin
              mode_nxt = MODE_BODY;
            end else begin
              mode_nxt = MODE_HEX1;
              hex_nxt  = '0;
              dig_nxt  = 2'd0;
            end
          end
          MODE_HEX1, MODE_HEX2: begin
            hex_nxt = hex_new;
            if (dig_r != 2'd3) begin
              dig_nxt = dig_r + 2'd1;
            end else begin
              dig_nxt = 2'd0;
              if (mode_r == MODE_HEX1 && is_hi) begin
                hi_nxt   = hex_new;
                mode_nxt = MODE_SUR_BS;
              end else begin
                mode_nxt = MODE_BODY;
              end
            end
          end
          MODE_SUR_BS: mode_nxt = MODE_SUR_U;
          MODE_SUR_U: begin
            mode_nxt = MODE_HEX2;
            hex_nxt  = '0;
            dig_nxt  = 2'd0;
          end
          default: mode_nxt = MODE_IDLE;
        endcase
        if (data) begin
          cnt_nxt = cnt_add;
        end
      end
    end
  end

  // Command to the queue
  always_comb begin
    push              = accept && (fail || done || data);
    push_cmd          = '0;
    push_cmd.kind     = KIND_DATA;
    push_cmd.err      = ERR_NONE;
    if (fail) begin
      push_cmd.kind = KIND_ERR;
      push_cmd.err  = fail_code;
    end else if (done) begin
      push_cmd.kind = KIND_DONE;
      push_cmd.len  = len16;
    end else begin
      push_cmd.last_idx = enc_last;
      push_cmd.bytes    = enc_bytes;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      hex_r  <= '0;
      hi_r   <= '0;
      dig_r  <= 2'd0;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
      hi_r   <= hi_nxt;
      dig_r  <= dig_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- sv/jsu_queue.sv -----
// ----------------------------------------------------------------------------
// jsu_queue: command queue
// Small register FIFO between scanner and output sequencer.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output cmd_t   head,
  output qstat_t qstat
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign head        = mem_r[rd_r];

  // Pointer and fill count
  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty) else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

endmodule

// ----- sv/jsu_back.sv -----
// ----------------------------------------------------------------------------
// jsu_back: output sequencer
// Walks the head command one result per cycle, while the output register is free
// or draining, into the output register and flags the last result of each item.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        head,
  input  qstat_t      qstat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_string_length,
  output logic        out_last
);

  logic        valid_r, valid_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [7:0]  byte_r;
  kind_t       kind_r;
  logic [2:0]  err_r;
  logic [15:0] len_r;
  logic        last_r;

  logic        load;
  logic        at_last;

  // Output register free or draining this cycle, and a command waiting
  assign load    = (!valid_r || out_ready) && !qstat.empty;
  assign at_last = (sub_r == head.last_idx);
  assign pop     = load && at_last;

  always_comb begin
    sub_nxt   = sub_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      sub_nxt   = at_last ? 2'd0 : sub_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.bytes[sub_r];
      kind_r <= head.kind;
      err_r  <= head.err;
      len_r  <= head.len;
      last_r <= at_last;
    end
  end

  assign out_valid         = valid_r;
  assign out_byte          = byte_r;
  assign out_kind          = kind_r;
  assign out_error_code    = err_r;
  assign out_string_length = len_r;
  assign out_last          = last_r;

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != KIND_DATA) |-> last_r)
    else $error("done/error result not marked last");
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((kind_r == KIND_ERR) == (err_r != ERR_NONE)))
    else $error("error code does not match kind");
  a_mid_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (sub_r != 2'd0) |-> !qstat.empty)
    else $error("partial command with empty queue");

endmodule

// ----- sv/json_string_unescape_utf8.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: streaming JSON string unescaper, UTF-8 output
// Top level: scanner, command queue and output sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_byte) takes one text byte per item.
//   Output channel (out_valid/out_ready/out_*) delivers results: data bytes,
//   a string-complete marker with its length, or an error with its code.
//   out_last marks the final result caused by one input item.
// Throughput: one input item per cycle while the queue has room; results
//   leave at one per cycle while out_ready is high, so an item that decodes
//   to N UTF-8 bytes (N up to 4) holds the output side for N results, and the
//   4-entry command queue absorbs the difference.
// Path: an accepted item is registered into the queue, then into the output
//   register, where its first result appears.
// Reset: synchronous active-low rst_n returns the scanner to idle, empties
//   the queue and drops any pending result.
// Receiver stall: the output register holds; the scanner keeps accepting
//   until the queue fills, then in_ready drops.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_string_length,
  output logic        out_last
);

  qstat_t qstat;
  logic   push;
  logic   pop;
  cmd_t   push_cmd;
  cmd_t   head;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .qstat    (qstat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  jsu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .qstat             (qstat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_kind          (out_kind),
    .out_error_code    (out_error_code),
    .out_string_length (out_string_length),
    .out_last          (out_last)
  );

endmodule

// ----- tb/sv/jsu_stream_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jsu_stream_checker: result checker for the JSON string unescaper
// Watches both channels. Every accepted text byte runs through a local copy
// of the unescape state machine, which queues the results it should cause.
// Every accepted result is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module jsu_stream_checker import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic [1:0]  out_kind,
  input  logic [2:0]  out_error_code,
  input  logic [15:0] out_string_length,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // One expected result
  typedef struct {
    logic [7:0]  data;
    kind_t       kind;
    logic [2:0]  err;
    logic [15:0] len;
    logic        last;
  } decoded_t;

  decoded_t decoded_q[$];
  decoded_t want;

  // Local copy of the scanner state
  mode_t                  scan_mode;
  logic [15:0]            hex_acc;
  logic [15:0]            high_half;
  logic [1:0]             digits;
  logic [LENGTH_BITS-1:0] decoded_len;

  // starts at zero, as do the two outputs
  int mismatches;

  // One line per mismatch; printing stops after a while, counting does not
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (mismatches < 100) begin
      $display("%0t ns: %s: got 0x%0h, wanted 0x%0h", $time, what, got, exp_val);
    end
    mismatches++;
  endtask

  function automatic int hex_nibble(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch - "0");
    if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
    if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
    return -1;
  endfunction

  task automatic push_result(logic [7:0] data, kind_t kind, logic [2:0] err,
                             logic [15:0] len);
    decoded_t r;
    r.data = data;
    r.kind = kind;
    r.err  = err;
    r.len  = len;
    r.last = 1'b0;
    decoded_q.push_back(r);
  endtask

  // Data byte, length counter saturates
  task automatic push_data(logic [7:0] data);
    push_result(data, KIND_DATA, ERR_NONE, 16'h0);
    if (decoded_len != '1) decoded_len++;
  endtask

  // Any error drops the string and returns to idle
  task automatic push_error(logic [2:0] code);
    push_result(8'h00, KIND_ERR, code, 16'h0);
    scan_mode   = MODE_IDLE;
    decoded_len = '0;
    digits      = 2'd0;
  endtask

  task automatic push_done();
    logic [31:0] wide;
    wide = 32'(decoded_len);
    push_result(8'h00, KIND_DONE, ERR_NONE, (wide > 32'hFFFF) ? 16'hFFFF : wide[15:0]);
  endtask

  // Code point to one..four UTF-8 bytes
  task automatic encode_point(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      push_data(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      push_data({3'b110, cp[10:6]});
      push_data({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      push_data({4'b1110, cp[15:12]});
      push_data({2'b10, cp[11:6]});
      push_data({2'b10, cp[5:0]});
    end else begin
      push_data({5'b11110, cp[20:18]});
      push_data({2'b10, cp[17:12]});
      push_data({2'b10, cp[11:6]});
      push_data({2'b10, cp[5:0]});
    end
  endtask

  // Advance the scanner by one text byte, queue what it causes
  task automatic unescape_byte(logic [7:0] ch);
    int       first;
    int       nib;
    decoded_t tail;
    first = decoded_q.size();
    case (scan_mode)
      MODE_IDLE: begin
        if (ch == CH_QUOTE) begin
          scan_mode   = MODE_BODY;
          decoded_len = '0;
        end else begin
          push_error(ERR_SURR);
        end
      end
      MODE_BODY: begin
        if (ch == CH_QUOTE) begin
          push_done();
          scan_mode   = MODE_IDLE;
          decoded_len = '0;
        end else if (ch == CH_BSLASH) begin
          scan_mode = MODE_ESC;
        end else if (ch == 8'h00) begin
          push_error(ERR_NOQUOTE);
        end else if (ch < 8'h20) begin
          push_error(ERR_CTRL);
        end else begin
          push_data(ch);
        end
      end
      MODE_ESC: begin
        scan_mode = MODE_BODY;
        case (ch)
          CH_QUOTE:  push_data(CH_QUOTE);
          CH_BSLASH: push_data(CH_BSLASH);
          "/":       push_data("/");
          "b":       push_data(8'h08);
          "f":       push_data(8'h0C);
          "n":       push_data(8'h0A);
          "r":       push_data(8'h0D);
          "t":       push_data(8'h09);
          "u": begin
            scan_mode = MODE_HEX1;
            hex_acc   = 16'h0;
            digits    = 2'd0;
          end
          default:   push_error(ERR_ESCAPE);
        endcase
      end
      MODE_HEX1, MODE_HEX2: begin
        nib = hex_nibble(ch);
        if (nib < 0) begin
          push_error(ERR_HEX);
        end else begin
          hex_acc = {hex_acc[11:0], 4'(nib)};
          if (digits < 2'd3) begin
            digits++;
          end else begin
            digits = 2'd0;
            if (scan_mode == MODE_HEX1) begin
              if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                high_half = hex_acc;
                scan_mode = MODE_SUR_BS;
              end else begin
                scan_mode = MODE_BODY;
                encode_point({5'b0, hex_acc});
              end
            end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
              push_error(ERR_SURR);
            end else begin
              // join the pair: 10 bits from each half, plus 0x10000
              scan_mode = MODE_BODY;
              encode_point(21'h10000 + {1'b0, high_half[9:0], hex_acc[9:0]});
            end
          end
        end
      end
      MODE_SUR_BS: begin
        if (ch == CH_BSLASH) scan_mode = MODE_SUR_U;
        else push_error(ERR_SURR);
      end
      MODE_SUR_U: begin
        if (ch == "u") begin
          scan_mode = MODE_HEX2;
          hex_acc   = 16'h0;
          digits    = 2'd0;
        end else begin
          push_error(ERR_SURR);
        end
      end
      default: push_error(ERR_SURR);
    endcase
    // mark the final result of this byte
    if (decoded_q.size() > first) begin
      tail = decoded_q.pop_back();
      tail.last = 1'b1;
      decoded_q.push_back(tail);
    end
  endtask

  // Predict on accepted bytes, compare accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      scan_mode   = MODE_IDLE;
      hex_acc     = 16'h0;
      high_half   = 16'h0;
      digits      = 2'd0;
      decoded_len = '0;
      decoded_q.delete();
    end else begin
      if (in_valid && in_ready) unescape_byte(in_byte);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing expected, kind", 32'(out_kind), 32'h0);
        end else begin
          want = decoded_q.pop_front();
          if (out_kind !== want.kind)
            report_mismatch("kind", 32'(out_kind), 32'(want.kind));
          if (out_byte !== want.data)
            report_mismatch("byte", 32'(out_byte), 32'(want.data));
          if (out_error_code !== want.err)
            report_mismatch("error code", 32'(out_error_code), 32'(want.err));
          if (out_string_length !== want.len)
            report_mismatch("string length", 32'(out_string_length), 32'(want.len));
          if (out_last !== want.last)
            report_mismatch("last", 32'(out_last), 32'(want.last));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= decoded_q.size();
  end

endmodule

// ----- tb/sv/tb_json_string_unescape_utf8.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8: testbench top for the JSON string unescaper
// Builds a text stream (directed strings, then random well-formed and broken
// strings with some noise), feeds it in bursts, stalls the result side on
// changing patterns with one long hold-off, and gives the verdict from the
// checker's mismatch count and pending results.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8;
  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 480;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic [2:0]  out_error_code;
  logic [15:0] out_string_length;
  logic        out_last;

  int fail_count;
  int pending;

  logic [7:0] text_q[$];
  int         sent_count;
  int         directed_size;
  int         burst_left;
  int         gap_left;
  int         cycle_count;
  int         stall_style;
  int         phase_left;
  int         pattern_ctr;
  int         hold_ctr;
  logic       long_hold_done;

  json_string_unescape_utf8 DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_kind          (out_kind),
    .out_error_code    (out_error_code),
    .out_string_length (out_string_length),
    .out_last          (out_last)
  );

  jsu_stream_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_kind          (out_kind),
    .out_error_code    (out_error_code),
    .out_string_length (out_string_length),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL json_string_unescape_utf8");
      $finish;
    end
  end

  // ---- text stream builders ----
  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // \uXXXX with random letter case per digit
  task automatic push_hex_escape(logic [15:0] v);
    logic [3:0] nib;
    push_text("\\u");
    for (int i = 3; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 4'd10) text_q.push_back(8'("0") + 8'(nib));
      else if ($urandom_range(0, 1)) text_q.push_back(8'("A") + 8'(nib) - 8'd10);
      else text_q.push_back(8'("a") + 8'(nib) - 8'd10);
    end
  endtask

  function automatic logic [15:0] pick_low_half();
    return 16'($urandom_range(16'hDC00, 16'hDFFF));
  endfunction

  function automatic logic [15:0] pick_high_half();
    return 16'($urandom_range(16'hD800, 16'hDBFF));
  endfunction

  function automatic logic is_hex_char(logic [7:0] ch);
    return (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f");
  endfunction

  // One well-formed element of a string body
  task automatic push_piece();
    string      esc_set;
    logic [7:0] ch;
    esc_set = "\"\\/bfnrt";
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        do ch = 8'($urandom_range(8'h20, 8'hFF));
        while (ch == "\"" || ch == "\\");
        text_q.push_back(ch);
      end
      4: begin
        text_q.push_back("\\");
        text_q.push_back(esc_set[$urandom_range(0, 7)]);
      end
      5: push_hex_escape(16'($urandom_range(0, 16'h7F)));
      6: push_hex_escape(16'($urandom_range(16'h80, 16'h7FF)));
      7: begin
        if ($urandom_range(0, 1)) push_hex_escape(16'($urandom_range(16'h800, 16'hD7FF)));
        else push_hex_escape(16'($urandom_range(16'hE000, 16'hFFFF)));
      end
      8: push_hex_escape(pick_low_half());
      default: begin
        push_hex_escape(pick_high_half());
        push_hex_escape(pick_low_half());
      end
    endcase
  endtask

  task automatic push_good_string();
    text_q.push_back("\"");
    repeat ($urandom_range(0, 12)) push_piece();
    text_q.push_back("\"");
  endtask

  // A string that breaks off with one kind of fault
  task automatic push_broken_string();
    logic [7:0]  ch;
    logic [15:0] v;
    text_q.push_back("\"");
    repeat ($urandom_range(0, 5)) push_piece();
    case ($urandom_range(0, 7))
      0: text_q.push_back(8'h00);
      1: text_q.push_back(8'($urandom_range(1, 8'h1F)));
      2: begin
        text_q.push_back("\\");
        do ch = 8'($urandom_range(0, 255));
        while (ch == "\"" || ch == "\\" || ch == "/" || ch == "b" || ch == "f" ||
               ch == "n" || ch == "r" || ch == "t" || ch == "u");
        text_q.push_back(ch);
      end
      3: begin
        push_text("\\u");
        repeat ($urandom_range(0, 3)) text_q.push_back("7");
        do ch = 8'($urandom_range(0, 255));
        while (is_hex_char(ch));
        text_q.push_back(ch);
      end
      4: begin
        push_hex_escape(pick_high_half());
        do ch = 8'($urandom_range(0, 255));
        while (ch == "\\");
        text_q.push_back(ch);
      end
      5: begin
        push_hex_escape(pick_high_half());
        text_q.push_back("\\");
        do ch = 8'($urandom_range(0, 255));
        while (ch == "u");
        text_q.push_back(ch);
      end
      6: begin
        push_hex_escape(pick_high_half());
        do v = 16'($urandom_range(0, 16'hFFFF));
        while (v >= 16'hDC00 && v <= 16'hDFFF);
        push_hex_escape(v);
      end
      default: begin
        push_hex_escape(pick_high_half());
        push_text("\\uD");
        do ch = 8'($urandom_range(0, 255));
        while (is_hex_char(ch));
        text_q.push_back(ch);
      end
    endcase
  endtask

  // Stray bytes between strings, never a quote
  task automatic push_noise();
    logic [7:0] ch;
    repeat ($urandom_range(1, 4)) begin
      do ch = 8'($urandom_range(0, 255));
      while (ch == "\"");
      text_q.push_back(ch);
    end
  endtask

  task automatic build_directed();
    text_q.push_back(8'h00);                     // end of text while idle
    push_text("x");                              // plain byte while idle
    push_text("\"");                             // plain byte extremes
    text_q.push_back(8'h20);
    text_q.push_back(8'h7F);
    text_q.push_back(8'h80);
    text_q.push_back(8'hFF);
    push_text("\"");
    push_text("\"\"");                           // empty string
    push_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\""); // every simple escape
    push_text("\"\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF\"");
    push_text("\"\\uD800\\uDC00\\udbff\\udfff\""); // surrogate pairs
    push_text("\"\\uDC00\"");                    // lone low surrogate
    push_text("\"\\uDBFF\"");                    // high surrogate, then quote
    push_text("\"");                             // end of text in body
    text_q.push_back(8'h00);
    push_text("\"");                             // control character
    text_q.push_back(8'h1F);
    push_text("\"\\q");                          // unknown escape
    push_text("\"\\");                           // end of text after backslash
    text_q.push_back(8'h00);
    push_text("\"\\u12g");                       // bad hex digit
    push_text("\"\\u1");                         // end of text among digits
    text_q.push_back(8'h00);
    push_text("\"\\uD800\\x");                   // high surrogate, no 'u'
    push_text("\"\\uD800\\");                    // end of text before 'u'
    text_q.push_back(8'h00);
    push_text("\"\\uD800\\uE000");               // second half not low
    push_text("\"\\uD800\\uDCz");                // bad digit in second half
  endtask

  // ---- result side: changing stall patterns, one long hold-off ----
  initial begin
    out_ready      = 1'b0;
    long_hold_done = 1'b0;
    phase_left     = 0;
    stall_style    = 0;
    pattern_ctr    = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!long_hold_done && sent_count >= 150) begin
        // hold off long enough for the queue to fill and stall the input
        long_hold_done = 1'b1;
        out_ready = 1'b0;
        for (hold_ctr = 0; hold_ctr < 300; hold_ctr++) @(negedge clk);
      end
      if (phase_left == 0) begin
        stall_style = $urandom_range(0, 3);
        phase_left  = $urandom_range(20, 80);
      end
      phase_left--;
      pattern_ctr++;
      case (stall_style)
        0:       out_ready = 1'b1;
        1:       out_ready = 1'($urandom_range(0, 1));
        2:       out_ready = ($urandom_range(0, 3) == 0);
        default: out_ready = (pattern_ctr % 3 != 0);
      endcase
    end
  end

  // ---- stimulus and verdict ----
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    sent_count = 0;
    gap_left   = 0;
    burst_left = $urandom_range(1, 40);

    build_directed();
    directed_size = text_q.size();
    while (text_q.size() < directed_size + RANDOM_ITEMS) begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  push_good_string();
        [70:87]: push_broken_string();
        default: push_noise();
      endcase
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // bursts of items with random gaps between them
    while (sent_count < text_q.size()) begin
      @(negedge clk);
      if (gap_left > 0) begin
        in_valid = 1'b0;
        gap_left--;
      end else begin
        in_valid = 1'b1;
        in_byte  = text_q[sent_count];
      end
      @(posedge clk);
      if (in_valid && in_ready) begin
        sent_count++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    // drain, then idle for DRAIN_CYCLES to catch anything unexpected
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS json_string_unescape_utf8");
    end else begin
      $display("FAIL json_string_unescape_utf8");
    end
    $finish;
  end

endmodule
